/* design/sacft_pkg.sv */
// Shared types and constants of the set-associative cache tag lookup.
`default_nettype none

package sacft_pkg;

   // Address, storage and count sizes
   localparam int ADDR_W     = 48;
   localparam int SET_W      = 8;
   localparam int NUM_SETS   = 1 << SET_W;
   localparam int NUM_WAYS   = 8;
   localparam int WAY_W      = 3;
   localparam int WCNT_W     = 4;
   localparam int CNT_W      = 32;
   localparam int SHIFT_W    = 6;
   localparam int IDX_FLD_W  = 16;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_BITS = 2'd0,
      CSR_INDEX_BITS  = 2'd1,
      CSR_WAYS        = 2'd2,
      CSR_FIELD_ORDER = 2'd3
   } csr_idx_type;

   localparam logic [4:0] RST_OFFSET_BITS = 5'd6;
   localparam logic [3:0] RST_INDEX_BITS  = 4'd4;
   localparam logic [3:0] RST_WAYS        = 4'd1;
   localparam logic       RST_FIELD_ORDER = 1'b0;

   localparam logic ORDER_INDEX_LOW = 1'b0;

   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic [4:0] offset_bits;
      logic [3:0] index_bits;
      logic [3:0] ways;
      logic       field_order;
   } cfg_type;

   // One tag memory row: FIFO pointer, valid bits and tags of one set
   typedef struct packed {
      logic [WAY_W-1:0]                ptr;
      logic [NUM_WAYS-1:0]             valid;
      logic [NUM_WAYS-1:0][ADDR_W-1:0] tags;
   } row_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic             clear_en;
      logic [SET_W-1:0] clear_addr;
      logic             lookup_en;
      logic             update_en;
   } cmd_type;

endpackage

`default_nettype wire

/* design/sacft_csr.sv */
// Configuration register file of the cache tag lookup.
`default_nettype none

module sacft_csr import sacft_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register index and take the low bits of the data
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_idx_type'(csr_index))
            CSR_OFFSET_BITS: cfg_in.offset_bits = csr_write_data[4:0];
            CSR_INDEX_BITS:  cfg_in.index_bits  = csr_write_data[3:0];
            CSR_WAYS:        cfg_in.ways        = csr_write_data[3:0];
            CSR_FIELD_ORDER: cfg_in.field_order = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_bits <= RST_OFFSET_BITS;
         cfg_ff.index_bits  <= RST_INDEX_BITS;
         cfg_ff.ways        <= RST_WAYS;
         cfg_ff.field_order <= RST_FIELD_ORDER;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* design/sacft_ctrl.sv */
// Controller state machine: clearing pass, idle and tag update.
`default_nettype none

module sacft_ctrl import sacft_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic      busy,
   output cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [SET_W-1:0] clr_ff, clr_in;

   // Sequence clear, lookup and update
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      cmd.clear_en   = 1'b0;
      cmd.clear_addr = clr_ff;
      cmd.lookup_en  = 1'b0;
      cmd.update_en  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            clr_in       = clr_ff + 1'b1;
            if (clr_ff == SET_W'(NUM_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.lookup_en = 1'b1;
               state_in      = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update_en = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

/* design/sacft_dpath.sv */
// Datapath: address split, tag memory, way compare, FIFO refill and counters.
`default_nettype none

module sacft_dpath import sacft_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   input  wire cfg_type           cfg,
   input  wire logic              req_command,
   input  wire logic [ADDR_W-1:0] req_address,
   output logic                   rsp_valid,
   output logic                   rsp_hit,
   output logic                   rsp_memory_read,
   output logic                   rsp_memory_write,
   output logic [CNT_W-1:0]       rsp_hit_count,
   output logic [CNT_W-1:0]       rsp_miss_count,
   output logic [CNT_W-1:0]       rsp_read_count,
   output logic [CNT_W-1:0]       rsp_write_count
);

   row_type mem [NUM_SETS];

   row_type             rd_row_ff;
   logic [ADDR_W-1:0]   tag_ff;
   logic [SET_W-1:0]    set_ff;
   logic                wr_ff;

   logic [SHIFT_W-1:0]  tag_sh;
   logic [SHIFT_W-1:0]  set_sh;
   logic [ADDR_W-1:0]   tag_mask;
   logic [ADDR_W-1:0]   set_shifted;
   logic [IDX_FLD_W-1:0] set_field;
   logic [SET_W-1:0]    set_in;
   logic [ADDR_W-1:0]   tag_in;

   logic [WCNT_W-1:0]   nways;
   logic [NUM_WAYS-1:0] way_hit;
   logic                hit;
   logic [WAY_W-1:0]    victim;
   logic [WCNT_W-1:0]   next_ptr;
   row_type             new_row;

   logic                rsp_valid_ff;
   logic                hit_ff, mrd_ff, mwr_ff;
   logic [CNT_W-1:0]    hit_cnt_ff, miss_cnt_ff, read_cnt_ff, write_cnt_ff;

   // Split the address into set and tag
   always_comb begin
      tag_sh = SHIFT_W'(cfg.offset_bits) + SHIFT_W'(cfg.index_bits);
      if (cfg.field_order == ORDER_INDEX_LOW) begin
         set_sh   = SHIFT_W'(cfg.offset_bits);
         tag_mask = '1;
         tag_in   = req_address >> tag_sh;
      end else begin
         set_sh   = SHIFT_W'(ADDR_W) - SHIFT_W'(cfg.index_bits);
         tag_mask = {ADDR_W{1'b1}} >> tag_sh;
         tag_in   = (req_address >> cfg.offset_bits) & tag_mask;
      end
      set_shifted = req_address >> set_sh;
      set_field   = set_shifted[IDX_FLD_W-1:0] & ~({IDX_FLD_W{1'b1}} << cfg.index_bits);
      set_in      = set_field[SET_W-1:0];
   end

   // Read the set row and hold the request
   always_ff @(posedge clock) begin
      if (cmd.lookup_en) begin
         rd_row_ff <= mem[set_in];
         tag_ff    <= tag_in;
         set_ff    <= set_in;
         wr_ff     <= req_command;
      end
   end

   // Compare ways and pick the FIFO victim
   always_comb begin
      if (cfg.ways == '0) begin
         nways = WCNT_W'(1);
      end else if (cfg.ways > WCNT_W'(NUM_WAYS)) begin
         nways = WCNT_W'(NUM_WAYS);
      end else begin
         nways = cfg.ways;
      end
      for (int w = 0; w < NUM_WAYS; w++) begin
         way_hit[w] = (WCNT_W'(w) < nways) && rd_row_ff.valid[w]
                      && (rd_row_ff.tags[w] == tag_ff);
      end
      hit = |way_hit;
      if ({1'b0, rd_row_ff.ptr} >= nways) begin
         victim = '0;
      end else begin
         victim = rd_row_ff.ptr;
      end
      next_ptr = {1'b0, victim} + 1'b1;
      new_row  = rd_row_ff;
      new_row.ptr = (next_ptr == nways) ? '0 : next_ptr[WAY_W-1:0];
      new_row.valid[victim] = 1'b1;
      new_row.tags[victim]  = tag_ff;
   end

   // Clear rows after reset, refill on a miss
   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         mem[cmd.clear_addr] <= '0;
      end else if (cmd.update_en && !hit) begin
         mem[set_ff] <= new_row;
      end
   end

   // Advance the saturating counts and register the result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         read_cnt_ff  <= '0;
         write_cnt_ff <= '0;
      end else begin
         rsp_valid_ff <= cmd.update_en;
         if (cmd.update_en) begin
            if (hit) begin
               if (hit_cnt_ff != '1) hit_cnt_ff <= hit_cnt_ff + 1'b1;
            end else begin
               if (miss_cnt_ff != '1) miss_cnt_ff <= miss_cnt_ff + 1'b1;
               if (read_cnt_ff != '1) read_cnt_ff <= read_cnt_ff + 1'b1;
            end
            if (wr_ff == CMD_WRITE && write_cnt_ff != '1) begin
               write_cnt_ff <= write_cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update_en) begin
         hit_ff <= hit;
         mrd_ff <= !hit;
         mwr_ff <= (wr_ff == CMD_WRITE);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_memory_read  = mrd_ff;
   assign rsp_memory_write = mwr_ff;
   assign rsp_hit_count    = hit_cnt_ff;
   assign rsp_miss_count   = miss_cnt_ff;
   assign rsp_read_count   = read_cnt_ff;
   assign rsp_write_count  = write_cnt_ff;

endmodule

`default_nettype wire

/* design/set_assoc_cache_fifo_tag_lookup.sv */
// Top level of the set-associative FIFO-replacement cache tag lookup.
// Usage:
//   Drive req_command (0 read, 1 write) and req_address with start high; the
//   access is taken at a clock edge where start is high and busy is low.
//   In the cycle after the transfer the block compares the ways of the set and
//   refills on a miss; the next cycle shows the result on the rsp_ ports for
//   exactly one cycle, marked by rsp_valid. The receiver cannot stall.
//   A new access is taken only after the update state has passed; the tag row
//   memory is read in the accept cycle and written back in the update cycle.
//   The four counts saturate and also stay on the rsp_ count ports.
//   Configuration: csr_write_enable, csr_index and csr_write_data write one
//   register per cycle (0 offset bits, 1 index bits, 2 ways, 3 field order);
//   write only while the block is idle.
//   Reset: synchronous, active high. Afterwards a clearing pass
//   zeroes the valid bits and FIFO pointers of all 256 sets; busy stays high
//   through it. Configuration writes are taken during the pass.
`default_nettype none

module set_assoc_cache_fifo_tag_lookup import sacft_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_command,
   input  wire logic [ADDR_W-1:0]     req_address,
   output logic                       rsp_valid,
   output logic                       rsp_hit,
   output logic                       rsp_memory_read,
   output logic                       rsp_memory_write,
   output logic [CNT_W-1:0]           rsp_hit_count,
   output logic [CNT_W-1:0]           rsp_miss_count,
   output logic [CNT_W-1:0]           rsp_read_count,
   output logic [CNT_W-1:0]           rsp_write_count,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type cfg;
   cmd_type cmd;

   sacft_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   sacft_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   sacft_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cfg              (cfg),
      .req_command      (req_command),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_memory_read  (rsp_memory_read),
      .rsp_memory_write (rsp_memory_write),
      .rsp_hit_count    (rsp_hit_count),
      .rsp_miss_count   (rsp_miss_count),
      .rsp_read_count   (rsp_read_count),
      .rsp_write_count  (rsp_write_count)
   );

endmodule

`default_nettype wire
